[rtl/gccd_pkg.sv]
// Shared types and constants for the gravity compensated contact detector.
// Holds the item structs, register indexes, CORDIC constants and the Q30 product helper.
package gccd_pkg;

	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CFG_CONTACT_THRESHOLD = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_PROBE_MASS        = 2'd1;

	localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
	localparam logic [19:0]        G_Q16       = 20'd642908;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] torque_x;
		logic signed [31:0] torque_y;
		logic signed [31:0] torque_z;
		logic signed [31:0] roll_angle;
		logic signed [31:0] pitch_angle;
		logic signed [31:0] yaw_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] net_force_x;
		logic signed [31:0] net_force_y;
		logic signed [31:0] net_force_z;
		logic signed [31:0] net_torque_x;
		logic signed [31:0] net_torque_y;
		logic signed [31:0] net_torque_z;
		logic               contact;
	} out_item_t;

	// Data that rides alongside the arithmetic pipeline
	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] torque_x;
		logic signed [31:0] torque_y;
		logic signed [31:0] torque_z;
		logic               comp;
	} side_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:  r = 34'sh3243F6A8;
			5'd1:  r = 34'sh1DAC6705;
			5'd2:  r = 34'sh0FADBAFC;
			5'd3:  r = 34'sh07F56EA6;
			5'd4:  r = 34'sh03FEAB76;
			5'd5:  r = 34'sh01FFD55B;
			5'd6:  r = 34'sh00FFFAAA;
			5'd7:  r = 34'sh007FFF55;
			5'd8:  r = 34'sh003FFFEA;
			5'd9:  r = 34'sh001FFFFD;
			5'd10: r = 34'sh000FFFFF;
			5'd11: r = 34'sh0007FFFF;
			5'd12: r = 34'sh0003FFFF;
			5'd13: r = 34'sh0001FFFF;
			5'd14: r = 34'sh0000FFFF;
			5'd15: r = 34'sh00007FFF;
			5'd16: r = 34'sh00003FFF;
			5'd17: r = 34'sh00001FFF;
			5'd18: r = 34'sh00000FFF;
			5'd19: r = 34'sh000007FF;
			5'd20: r = 34'sh000003FF;
			5'd21: r = 34'sh000001FF;
			5'd22: r = 34'sh000000FF;
			5'd23: r = 34'sh0000007F;
			5'd24: r = 34'sh0000003F;
			5'd25: r = 34'sh0000001F;
			5'd26: r = 34'sh0000000F;
			5'd27: r = 34'sh00000008;
			5'd28: r = 34'sh00000004;
			5'd29: r = 34'sh00000002;
			5'd30: r = 34'sh00000001;
			default: r = 34'sh00000000;
		endcase
		return r;
	endfunction

	// Q30 by Q30, floored back to Q30
	function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
		input logic signed [33:0] b);
		logic signed [67:0] p;
		p = a * b;
		return p[63:30];
	endfunction

endpackage

[rtl/gravity_compensated_contact_detect_unit.sv]
// Top level of the gravity compensated contact detector: CORDIC, quaternion and
// compensation pipeline in one module. Depends on gccd_pkg.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | gccd_pkg::in_item_t
//   out     | output    | out_valid/out_stall | gccd_pkg::out_item_t
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The pipeline has one range-reduction stage, one stage per CORDIC iteration,
// then eight stages of products, sums, weighting, saturation and the contact
// compare. One item enters per cycle while no stall backs up to the input.
// Reset clears all valid bits and loads the register reset values. A stall
// holds each stage that has a valid item and nowhere to send it; empty stages
// keep filling, so no item is lost or repeated.
module gravity_compensated_contact_detect_unit #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  gccd_pkg::in_item_t        in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output gccd_pkg::out_item_t       out_item,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [gccd_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [18:0]               cfg_data
);

	localparam int CS = CORDIC_STAGES;
	localparam int NS = CS + 9;
	localparam int PA = CS + 1;

	// Configuration registers
	logic [18:0] threshold_q;
	logic [17:0] mass_q;
	logic [21:0] wt_q;
	logic [37:0] wt_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 19'd0;
			mass_q      <= 18'd32768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gccd_pkg::CFG_CONTACT_THRESHOLD: threshold_q <= cfg_data;
				gccd_pkg::CFG_PROBE_MASS:        mass_q      <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// Weight in unsigned Q6.16, registered from the mass every cycle
	assign wt_full = mass_q * gccd_pkg::G_Q16;
	always_ff @(posedge clk) begin
		wt_q <= wt_full[37:16];
	end

	// Pipeline flow control: a stage advances if empty or if the next one advances
	logic [NS-1:0] v_s;
	logic [NS:0]   en;

	assign en[NS] = !out_stall;
	genvar p;
	generate
		for (p = 0; p < NS; p++) begin : g_flow
			assign en[p] = !v_s[p] || en[p+1];
			if (p == 0) begin : g_head
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						v_s[p] <= 1'b0;
					end else if (en[p]) begin
						v_s[p] <= in_valid;
					end
				end
			end else begin : g_body
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						v_s[p] <= 1'b0;
					end else if (en[p]) begin
						v_s[p] <= v_s[p-1];
					end
				end
			end
		end
	endgenerate

	assign in_stall = !en[0];

	// Sideband: forces, torques and the compensation flag
	gccd_pkg::side_t side_s [0:NS-1];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s[0].force_x  <= in_item.force_x;
			side_s[0].force_y  <= in_item.force_y;
			side_s[0].force_z  <= in_item.force_z;
			side_s[0].torque_x <= in_item.torque_x;
			side_s[0].torque_y <= in_item.torque_y;
			side_s[0].torque_z <= in_item.torque_z;
			// compensate only when no angle is negative
			side_s[0].comp     <= !(in_item.roll_angle[31] || in_item.pitch_angle[31] ||
				in_item.yaw_angle[31]);
		end
	end

	generate
		for (p = 1; p < NS; p++) begin : g_side
			always_ff @(posedge clk) begin
				if (en[p]) side_s[p] <= side_s[p-1];
			end
		end
	endgenerate

	// CORDIC: axis 0 roll, 1 pitch, 2 yaw
	logic signed [33:0] cx_s   [0:2][0:CS];
	logic signed [33:0] cy_s   [0:2][0:CS];
	logic signed [33:0] cz_s   [0:2][0:CS];
	logic               flip_s [0:2][0:CS];
	logic signed [31:0] ang [0:2];

	assign ang[0] = in_item.roll_angle;
	assign ang[1] = in_item.pitch_angle;
	assign ang[2] = in_item.yaw_angle;

	genvar a, j;
	generate
		for (a = 0; a < 3; a++) begin : g_axis
			logic signed [33:0] h;
			logic               big;
			// raw Q3.28 read as Q2.29 is the half angle; carry it in Q30
			assign h   = {ang[a][31], ang[a], 1'b0};
			assign big = h > gccd_pkg::Q30_HALF_PI;

			always_ff @(posedge clk) begin
				if (en[0]) begin
					cx_s[a][0]   <= gccd_pkg::Q30_GAIN;
					cy_s[a][0]   <= '0;
					cz_s[a][0]   <= big ? h - gccd_pkg::Q30_PI : h;
					flip_s[a][0] <= big;
				end
			end

			for (j = 0; j < CS; j++) begin : g_iter
				logic signed [33:0] dx, dy, at;
				assign dx = cy_s[a][j] >>> j;
				assign dy = cx_s[a][j] >>> j;
				assign at = gccd_pkg::atan_q30(5'(j));
				always_ff @(posedge clk) begin
					if (en[j+1]) begin
						flip_s[a][j+1] <= flip_s[a][j];
						if (!cz_s[a][j][33]) begin
							cx_s[a][j+1] <= cx_s[a][j] - dx;
							cy_s[a][j+1] <= cy_s[a][j] + dy;
							cz_s[a][j+1] <= cz_s[a][j] - at;
						end else begin
							cx_s[a][j+1] <= cx_s[a][j] + dx;
							cy_s[a][j+1] <= cy_s[a][j] - dy;
							cz_s[a][j+1] <= cz_s[a][j] + at;
						end
					end
				end
			end
		end
	endgenerate

	// Half-angle sines and cosines, negated where range reduction folded the angle
	logic signed [33:0] sn [0:2];
	logic signed [33:0] cs [0:2];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sn[k] = flip_s[k][CS] ? -cy_s[k][CS] : cy_s[k][CS];
			cs[k] = flip_s[k][CS] ? -cx_s[k][CS] : cx_s[k][CS];
		end
	end

	// Stage 1: yaw by pitch products
	logic signed [33:0] sr_s1, cr_s1, cycp_s1, sysp_s1, sycp_s1, cysp_s1;
	always_ff @(posedge clk) begin
		if (en[PA]) begin
			sr_s1   <= sn[0];
			cr_s1   <= cs[0];
			cycp_s1 <= gccd_pkg::mul30(cs[2], cs[1]);
			sysp_s1 <= gccd_pkg::mul30(sn[2], sn[1]);
			sycp_s1 <= gccd_pkg::mul30(sn[2], cs[1]);
			cysp_s1 <= gccd_pkg::mul30(cs[2], sn[1]);
		end
	end

	// Stage 2: times roll terms
	logic signed [33:0] a1_s2, a2_s2, b1_s2, b2_s2, c1_s2, c2_s2, d1_s2, d2_s2;
	always_ff @(posedge clk) begin
		if (en[PA+1]) begin
			a1_s2 <= gccd_pkg::mul30(cycp_s1, cr_s1);
			a2_s2 <= gccd_pkg::mul30(sysp_s1, sr_s1);
			b1_s2 <= gccd_pkg::mul30(cycp_s1, sr_s1);
			b2_s2 <= gccd_pkg::mul30(sysp_s1, cr_s1);
			c1_s2 <= gccd_pkg::mul30(sycp_s1, sr_s1);
			c2_s2 <= gccd_pkg::mul30(cysp_s1, cr_s1);
			d1_s2 <= gccd_pkg::mul30(sycp_s1, cr_s1);
			d2_s2 <= gccd_pkg::mul30(cysp_s1, sr_s1);
		end
	end

	// Stage 3: quaternion
	logic signed [33:0] qw_s3, qx_s3, qy_s3, qz_s3;
	always_ff @(posedge clk) begin
		if (en[PA+2]) begin
			qw_s3 <= a1_s2 + a2_s2;
			qx_s3 <= b1_s2 - b2_s2;
			qy_s3 <= c1_s2 + c2_s2;
			qz_s3 <= d1_s2 - d2_s2;
		end
	end

	// Stage 4: quaternion products
	logic signed [33:0] xz_s4, wy_s4, wx_s4, yz_s4, ww_s4, xx_s4, yy_s4, zz_s4;
	always_ff @(posedge clk) begin
		if (en[PA+3]) begin
			xz_s4 <= gccd_pkg::mul30(qx_s3, qz_s3);
			wy_s4 <= gccd_pkg::mul30(qw_s3, qy_s3);
			wx_s4 <= gccd_pkg::mul30(qw_s3, qx_s3);
			yz_s4 <= gccd_pkg::mul30(qy_s3, qz_s3);
			ww_s4 <= gccd_pkg::mul30(qw_s3, qw_s3);
			xx_s4 <= gccd_pkg::mul30(qx_s3, qx_s3);
			yy_s4 <= gccd_pkg::mul30(qy_s3, qy_s3);
			zz_s4 <= gccd_pkg::mul30(qz_s3, qz_s3);
		end
	end

	// Stage 5: rotation matrix terms for the gravity direction
	logic signed [35:0] tx_s5, ty_s5, tz_s5;
	always_ff @(posedge clk) begin
		if (en[PA+4]) begin
			tx_s5 <= 36'(xz_s4) - 36'(wy_s4);
			ty_s5 <= 36'(wx_s4) + 36'(yz_s4);
			tz_s5 <= 36'(ww_s4) - 36'(xx_s4) - 36'(yy_s4) + 36'(zz_s4);
		end
	end

	// Stage 6: scale by weight; x and y carry the factor two in the shift
	logic signed [22:0] wt_sgn;
	logic signed [58:0] px, py, pz;
	logic signed [39:0] gx_s6, gy_s6, gz_s6;
	assign wt_sgn = {1'b0, wt_q};
	assign px = tx_s5 * wt_sgn;
	assign py = ty_s5 * wt_sgn;
	assign pz = tz_s5 * wt_sgn;
	always_ff @(posedge clk) begin
		if (en[PA+5]) begin
			gx_s6 <= 40'(px >>> 29);
			gy_s6 <= 40'(py >>> 29);
			gz_s6 <= 40'(pz >>> 30);
		end
	end

	// Stage 7: remove gravity (subtract on x and y, add on z) and saturate; uncompensated forces pass
	logic signed [40:0] rx, ry, rz;
	logic signed [31:0] nx_s7, ny_s7, nz_s7;
	assign rx = 41'(side_s[PA+5].force_x) - 41'(gx_s6);
	assign ry = 41'(side_s[PA+5].force_y) - 41'(gy_s6);
	assign rz = 41'(side_s[PA+5].force_z) + 41'(gz_s6);

	function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
		if (v > 41'sd2147483647)       return 32'sh7FFFFFFF;
		else if (v < -41'sd2147483648) return 32'sh80000000;
		else                           return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en[PA+6]) begin
			if (side_s[PA+5].comp) begin
				nx_s7 <= sat32(rx);
				ny_s7 <= sat32(ry);
				nz_s7 <= sat32(rz);
			end else begin
				nx_s7 <= side_s[PA+5].force_x;
				ny_s7 <= side_s[PA+5].force_y;
				nz_s7 <= side_s[PA+5].force_z;
			end
		end
	end

	// Stage 8: magnitude compare and output register
	logic [32:0] mx, my, mz, thr;
	assign mx  = nx_s7[31] ? 33'd0 - {nx_s7[31], nx_s7} : {1'b0, nx_s7};
	assign my  = ny_s7[31] ? 33'd0 - {ny_s7[31], ny_s7} : {1'b0, ny_s7};
	assign mz  = nz_s7[31] ? 33'd0 - {nz_s7[31], nz_s7} : {1'b0, nz_s7};
	assign thr = 33'(threshold_q);

	gccd_pkg::out_item_t res_s8;
	always_ff @(posedge clk) begin
		if (en[PA+7]) begin
			res_s8.net_force_x  <= nx_s7;
			res_s8.net_force_y  <= ny_s7;
			res_s8.net_force_z  <= nz_s7;
			res_s8.net_torque_x <= side_s[PA+6].torque_x;
			res_s8.net_torque_y <= side_s[PA+6].torque_y;
			res_s8.net_torque_z <= side_s[PA+6].torque_z;
			res_s8.contact      <= (mx >= thr) || (my >= thr) || (mz >= thr);
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_item  = res_s8;

	// Without back-pressure at the output nothing holds upstream
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall) else $error("input stalled with output free");

	// A zero threshold reports contact on every item
	a_zero_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && threshold_q == 19'd0) |-> out_item.contact)
		else $error("contact missing at zero threshold");

	// The weight register follows the mass in the next cycle
	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(mass_q) |=> wt_q == $past(wt_full[37:16]))
		else $error("weight register out of step");

	// Torques pass unchanged: the output torque equals the sideband one
	a_torque: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[NS-2] && en[NS-1]) |=> out_item.net_torque_x == $past(side_s[NS-2].torque_x))
		else $error("torque altered in pipeline");

endmodule

[sim/testbench.sv]
// Self-checking bench for the gravity compensated contact detector.
// It predicts each result in the bench itself and drives random handshakes on the in and out channels.
// Depends on gccd_pkg and gravity_compensated_contact_detect_unit.
`timescale 1ns / 100ps

module testbench;

	localparam int STAGES       = 24;
	localparam int DRAIN_CYCLES = STAGES + 9 + 8;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int PHASES       = 5;

	// Indexes outside the register list: the block must ignore writes to them
	localparam logic [gccd_pkg::CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [gccd_pkg::CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

	// Q30 angle constants, the Q16 weight constant and the truncated arctangent table
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint GAIN_Q30    = 64'sd652032874;
	localparam longint WEIGHT_Q16  = 64'sd642908;
	localparam longint ARCTAN_Q30 [STAGES] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	gccd_pkg::in_item_t            in_item;
	logic                          out_valid;
	logic                          out_stall;
	gccd_pkg::out_item_t           out_item;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [gccd_pkg::CfgIdxW-1:0]  cfg_index;
	logic [18:0]                   cfg_data;

	gravity_compensated_contact_detect_unit #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Bench copy of the two registers, updated on every accepted write
	logic [18:0] threshold_q16;
	logic [17:0] mass_q16;

	gccd_pkg::out_item_t pending_results [$];
	int        mismatches;
	int        cycle_count;

	typedef struct {
		gccd_pkg::in_item_t  stim;
		bit                  known;
		gccd_pkg::out_item_t want;
	} stim_row_t;

	stim_row_t directed_rows [$];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Product of two Q30 values, floored back to Q30
	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Rotation-mode CORDIC on a non-negative Q30 half angle; angles past a
	// quarter turn fold back by half a turn and flip both signs
	function automatic void half_angle_sincos(input longint h, output longint s,
		output longint c);
		longint x, y, z, dx, dy;
		bit     flip;
		x = GAIN_Q30;
		y = 0;
		z = h;
		flip = 1'b0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1'b1;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARCTAN_Q30[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARCTAN_Q30[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	// Expected result for one sample under the current register values
	function automatic gccd_pkg::out_item_t compensate(input gccd_pkg::in_item_t it);
		gccd_pkg::out_item_t r;
		longint f [3];
		longint net [3];
		longint roll, pitch, yaw;
		longint sr, cr, sp, cp, sy, cy, qw, qx, qy, qz, wt, t, mag;
		roll  = longint'(it.roll_angle);
		pitch = longint'(it.pitch_angle);
		yaw   = longint'(it.yaw_angle);
		f[0] = longint'(it.force_x);
		f[1] = longint'(it.force_y);
		f[2] = longint'(it.force_z);
		net = f;
		if (roll >= 0 && pitch >= 0 && yaw >= 0) begin
			half_angle_sincos(roll * 2, sr, cr);
			half_angle_sincos(pitch * 2, sp, cp);
			half_angle_sincos(yaw * 2, sy, cy);
			qw = q30_mul(q30_mul(cy, cp), cr) + q30_mul(q30_mul(sy, sp), sr);
			qx = q30_mul(q30_mul(cy, cp), sr) - q30_mul(q30_mul(sy, sp), cr);
			qy = q30_mul(q30_mul(sy, cp), sr) + q30_mul(q30_mul(cy, sp), cr);
			qz = q30_mul(q30_mul(sy, cp), cr) - q30_mul(q30_mul(cy, sp), sr);
			wt = (longint'(mass_q16) * WEIGHT_Q16) >>> 16;
			t = q30_mul(qx, qz) - q30_mul(qw, qy);
			net[0] = clamp32(f[0] - ((t * wt) >>> 29));
			t = q30_mul(qw, qx) + q30_mul(qy, qz);
			net[1] = clamp32(f[1] - ((t * wt) >>> 29));
			t = q30_mul(qw, qw) - q30_mul(qx, qx) - q30_mul(qy, qy) + q30_mul(qz, qz);
			net[2] = clamp32(f[2] + ((t * wt) >>> 30));
		end
		r.contact = 1'b0;
		for (int k = 0; k < 3; k++) begin
			mag = net[k] < 0 ? -net[k] : net[k];
			if (mag >= longint'(threshold_q16))
				r.contact = 1'b1;
		end
		r.net_force_x  = net[0][31:0];
		r.net_force_y  = net[1][31:0];
		r.net_force_z  = net[2][31:0];
		r.net_torque_x = it.torque_x;
		r.net_torque_y = it.torque_y;
		r.net_torque_z = it.torque_z;
		return r;
	endfunction

	function automatic gccd_pkg::in_item_t make_item(input logic [31:0] fx, fy, fz, tx, ty,
		tz, input logic [31:0] roll, pitch, yaw);
		gccd_pkg::in_item_t it;
		it = '{fx, fy, fz, tx, ty, tz, roll, pitch, yaw};
		return it;
	endfunction

	// A force value: half near the contact limit, a third full range, the rest extremes
	function automatic logic [31:0] rand_force();
		case ($urandom_range(0, 5))
			0, 1, 2: return $urandom_range(0, 32'd20 << 16) - (32'd10 << 16);
			3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 600000)
				: 32'h8000_0000 + $urandom_range(0, 600000);
			default: return $urandom;
		endcase
	endfunction

	// Angles: mostly all non-negative so that compensation runs, the rest any sign
	function automatic logic [31:0] rand_angle(input bit any_sign);
		if (any_sign)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return {1'b0, 31'($urandom_range(0, 31'h7FFF_FFFF))};
			1:       return 32'd843314856 + $urandom_range(0, 4) - 2;
			default: return $urandom_range(0, 32'd843314856);
		endcase
	endfunction

	function automatic gccd_pkg::in_item_t rand_item();
		bit any_sign;
		any_sign = ($urandom_range(0, 99) < 15);
		return make_item(rand_force(), rand_force(), rand_force(), $urandom, $urandom,
			$urandom, rand_angle(any_sign), rand_angle(any_sign), rand_angle(any_sign));
	endfunction

	// No gap half the time, otherwise mostly a short one, a long one now and then
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one item and hold it until taken; stall is sampled at the falling edge
	// ahead of the rising edge so nothing hangs on event order within the edge
	task automatic push_sample(input gccd_pkg::in_item_t it);
		bit held;
		int gap;
		gap = rand_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
		end while (held);
		pending_results.push_back(compensate(it));
	endtask

	task automatic push_row(input stim_row_t row);
		push_sample(row.stim);
		// Typed-in rows replace the predicted value with the one read off by hand
		if (row.known) begin
			void'(pending_results.pop_back());
			pending_results.push_back(row.want);
		end
	endtask

	// Drop valid and let everything in flight come out before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Present one write and hold it until taken; the caller drops valid
	task automatic write_reg(input logic [gccd_pkg::CfgIdxW-1:0] idx,
		input logic [18:0] val);
		bit ready;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			ready = cfg_ready;
			@(posedge clk);
		end while (!ready);
		case (idx)
			gccd_pkg::CFG_CONTACT_THRESHOLD: threshold_q16 = val;
			gccd_pkg::CFG_PROBE_MASS:        mass_q16 = val[17:0];
			default: ;
		endcase
	endtask

	task automatic add_row(input gccd_pkg::in_item_t it, input bit known,
		input gccd_pkg::out_item_t want);
		stim_row_t row;
		row.stim  = it;
		row.known = known;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// A sample with a negative angle passes through untouched; with the reset
	// threshold of zero, contact is always set
	task automatic add_passthrough(input gccd_pkg::in_item_t it);
		gccd_pkg::out_item_t want;
		want = '{it.force_x, it.force_y, it.force_z, it.torque_x, it.torque_y,
			it.torque_z, 1'b1};
		add_row(it, 1'b1, want);
	endtask

	task automatic build_directed();
		localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
		localparam logic [31:0] MAXN = 32'h8000_0000;
		localparam logic [31:0] QUARTER = 32'd843314856;
		add_passthrough(make_item(MAXP, MAXN, 0, MAXP, MAXN, 0, MAXN, 0, 0));
		add_passthrough(make_item(MAXN, MAXP, MAXP, MAXN, MAXP, 32'hFFFF_FFFF, 0, MAXN, 0));
		add_passthrough(make_item(0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		add_passthrough(make_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
			32'h5555_5555, 32'hAAAA_AAAA, 32'hF0F0_F0F0, MAXN, MAXN, MAXN));
		add_passthrough(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 5, 5));
		// Level probe, zero angles, and saturation in both directions
		add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(make_item(MAXP, MAXP, MAXP, 1, 2, 3, 0, 0, 0), 1'b0, '0);
		add_row(make_item(MAXN, MAXN, MAXN, 1, 2, 3, 0, 0, 0), 1'b0, '0);
		// Largest angles take the folded half-turn path
		add_row(make_item(0, 0, 0, 0, 0, 0, MAXP, MAXP, MAXP), 1'b0, '0);
		add_row(make_item(MAXN, MAXP, MAXN, 0, 0, 0, MAXP, MAXP, MAXP), 1'b0, '0);
		// Either side of a quarter-turn half angle
		add_row(make_item(0, 0, 0, 0, 0, 0, QUARTER, QUARTER, QUARTER), 1'b0, '0);
		add_row(make_item(0, 0, 0, 0, 0, 0, QUARTER + 1, QUARTER + 1, QUARTER + 1),
			1'b0, '0);
		add_row(make_item(32'h0001_0000, 0, 0, 0, 0, 0, QUARTER, 0, QUARTER + 1),
			1'b0, '0);
		add_row(make_item(0, 32'hFFFF_0000, 0, 0, 0, 0, 0, QUARTER + 1, 0), 1'b0, '0);
	endtask

	task automatic report(input gccd_pkg::out_item_t want, input gccd_pkg::out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: fx %h/%h fy %h/%h fz %h/%h tx %h/%h ty %h/%h tz %h/%h c %b/%b",
				$realtime, want.net_force_x, got.net_force_x, want.net_force_y,
				got.net_force_y, want.net_force_z, got.net_force_z, want.net_torque_x,
				got.net_torque_x, want.net_torque_y, got.net_torque_y, want.net_torque_z,
				got.net_torque_z, want.contact, got.contact);
	endtask

	// Output side: sample at the falling edge, act on it at the rising edge
	logic                seen_valid;
	logic                seen_stall;
	gccd_pkg::out_item_t seen_item;
	int                  stall_left;
	bit                  stall_quiet;

	always @(negedge clk) begin
		seen_valid <= out_valid;
		seen_stall <= out_stall;
		seen_item  <= out_item;
	end

	always @(posedge clk) begin
		gccd_pkg::out_item_t want;
		if (arst_n && seen_valid && !seen_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at %0t", $realtime);
			end else begin
				want = pending_results.pop_front();
				if (want.net_force_x !== seen_item.net_force_x
					|| want.net_force_y !== seen_item.net_force_y
					|| want.net_force_z !== seen_item.net_force_z
					|| want.net_torque_x !== seen_item.net_torque_x
					|| want.net_torque_y !== seen_item.net_torque_y
					|| want.net_torque_z !== seen_item.net_torque_z
					|| want.contact !== seen_item.contact)
					report(want, seen_item);
			end
		end
		// Stall in bursts, with quiet stretches where the sink never holds off
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 299) == 0)
				stall_quiet = !stall_quiet;
			if (!stall_quiet && $urandom_range(0, 99) < 25)
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		logic [18:0] thresholds [PHASES];
		logic [18:0] masses [PHASES];
		int per_phase;
		thresholds = '{19'd0, 19'd327680, 19'h7FFFF, 19'd65536, 19'd0};
		masses     = '{19'd0, 19'd131072, 19'h7FFFF, 19'd32768, 19'd98304};
		per_phase  = RANDOM_ITEMS / PHASES;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_item     = '0;
		out_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = gccd_pkg::CFG_CONTACT_THRESHOLD;
		cfg_data    = '0;
		stall_left  = 0;
		stall_quiet = 1'b0;
		mismatches  = 0;
		cycle_count = 0;
		seen_valid  = 1'b0;
		seen_stall  = 1'b0;
		seen_item   = '0;
		threshold_q16 = 19'd0;
		mass_q16      = 18'd32768;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs on the register reset values
		build_directed();
		foreach (directed_rows[i])
			push_row(directed_rows[i]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			// Spare indexes must leave both registers as they are
			write_reg(CFG_SPARE_2, 19'($urandom));
			write_reg(gccd_pkg::CFG_CONTACT_THRESHOLD, thresholds[p]);
			write_reg(gccd_pkg::CFG_PROBE_MASS, masses[p]);
			write_reg(CFG_SPARE_3, 19'($urandom));
			cfg_valid <= 1'b0;
			for (int n = 0; n < per_phase; n++) begin
				push_sample(rand_item());
				// Hold off once until the pipeline has fully emptied
				if (p == 2 && n == per_phase / 2) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[gravity_compensated_contact_detect_unit.f]
rtl/gccd_pkg.sv
rtl/gravity_compensated_contact_detect_unit.sv
sim/testbench.sv
